>>> hw/rtl/gls_pkg.sv
// shared types, pattern codes and level tables for the graticule line stepper
package gls_pkg;

  typedef logic [3:0] pattern_t;
  typedef logic [5:0] step_t;
  typedef logic [6:0] len_t;
  typedef logic [3:0] dot_t;
  typedef logic [7:0] level_t;

  localparam pattern_t PAT_OFF     = 4'd0;
  localparam pattern_t PAT_HORIZ   = 4'd1;
  localparam pattern_t PAT_VERT    = 4'd2;
  localparam pattern_t PAT_XH_H    = 4'd3;
  localparam pattern_t PAT_XH_V    = 4'd4;
  localparam pattern_t PAT_DOTS    = 4'd5;
  localparam pattern_t PAT_HORIZ_F = 4'd6;
  localparam pattern_t PAT_VERT_F  = 4'd7;
  localparam pattern_t PAT_XH_H_F  = 4'd8;
  localparam pattern_t PAT_XH_V_F  = 4'd9;
  localparam pattern_t PAT_RESET   = PAT_XH_H_F;

  localparam len_t HZ_LEN  = 7'd11;
  localparam len_t VT_LEN  = 7'd13;
  localparam len_t HZF_LEN = 7'd52;
  localparam len_t VTF_LEN = 7'd64;

  localparam level_t TAB_H [11] = '{
    8'd68, 8'd88, 8'd108, 8'd128, 8'd148, 8'd148, 8'd148, 8'd168, 8'd188, 8'd208, 8'd228};

  localparam level_t TAB_V [13] = '{
    8'd48, 8'd68, 8'd88, 8'd108, 8'd128, 8'd148, 8'd148, 8'd148, 8'd168, 8'd188,
    8'd208, 8'd228, 8'd248};

  localparam level_t TAB_HF [52] = '{
    8'd68, 8'd68, 8'd72, 8'd76, 8'd80, 8'd84, 8'd88, 8'd88, 8'd92, 8'd96,
    8'd100, 8'd104, 8'd108, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd128,
    8'd132, 8'd136, 8'd140, 8'd144, 8'd148, 8'd148, 8'd148, 8'd148, 8'd152, 8'd156,
    8'd160, 8'd164, 8'd168, 8'd168, 8'd172, 8'd176, 8'd180, 8'd184, 8'd188, 8'd188,
    8'd192, 8'd196, 8'd200, 8'd204, 8'd208, 8'd208, 8'd212, 8'd216, 8'd220, 8'd224,
    8'd228, 8'd228};

  localparam level_t TAB_VF [64] = '{
    8'd48, 8'd48, 8'd52, 8'd56, 8'd60, 8'd64, 8'd68, 8'd68, 8'd72, 8'd76,
    8'd80, 8'd84, 8'd88, 8'd88, 8'd92, 8'd96, 8'd100, 8'd104, 8'd108, 8'd108,
    8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd128, 8'd132, 8'd136, 8'd140, 8'd144,
    8'd148, 8'd148, 8'd148, 8'd148, 8'd152, 8'd156, 8'd160, 8'd164, 8'd168, 8'd168,
    8'd172, 8'd176, 8'd180, 8'd184, 8'd188, 8'd188, 8'd192, 8'd196, 8'd200, 8'd204,
    8'd208, 8'd208, 8'd212, 8'd216, 8'd220, 8'd224, 8'd228, 8'd228, 8'd232, 8'd236,
    8'd240, 8'd244, 8'd248, 8'd248};

endpackage

>>> hw/rtl/gls_in_if.sv
// request channel carrying sweep-end events
interface gls_in_if;
  logic valid;
  logic ready;
  logic sweep_end;

  modport source (output valid, output sweep_end, input ready);
  modport sink (input valid, input sweep_end, output ready);
endinterface

>>> hw/rtl/gls_out_if.sv
// result channel carrying dac and mode register loads
interface gls_out_if;
  logic       valid;
  logic       ready;
  logic       y_load;
  logic [7:0] y_level;
  logic       x_load;
  logic [7:0] x_level;
  logic       mode_load;
  logic       mode_value;

  modport source (output valid, output y_load, output y_level, output x_load,
                  output x_level, output mode_load, output mode_value, input ready);
  modport sink (input valid, input y_load, input y_level, input x_load,
                input x_level, input mode_load, input mode_value, output ready);
endinterface

>>> hw/rtl/graticule_line_stepper.sv
// graticule line stepper: level tables, step counters and result register
// a request's result is registered in the result register as the request is accepted
// throughput: one request per cycle while results are drained; the single result register is the only stage
// a request is taken whenever the result register is empty or being drained
// reset: pattern returns to fine horizontal-first crosshatch, counters and phase clear,
// result register empties
module graticule_line_stepper
  import gls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data,
  gls_in_if.sink       in_ch,
  gls_out_if.source    out_ch
);

  pattern_t pattern;
  step_t    step_index;
  step_t    step_index_next;
  dot_t     dot_quo;
  dot_t     dot_quo_next;
  logic     vertical_phase;
  logic     vertical_phase_next;

  logic     out_valid;
  logic     y_load, x_load, mode_load, mode_value;
  level_t   y_level, x_level;

  logic     r_y_load, r_x_load, r_mode_load, r_mode_value;
  level_t   r_y_level, r_x_level;

  logic     fire;
  logic     active;
  logic     is_dots, is_fine, is_xhatch, is_vert, wrap;
  len_t     tab_len;
  step_t    step_cur;
  len_t     step_inc;
  dot_t     dot_rem, dot_row;
  level_t   level;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    is_dots   = (pattern == PAT_DOTS);
    is_fine   = (pattern >= PAT_HORIZ_F);
    is_xhatch = (pattern == PAT_XH_H) || (pattern == PAT_XH_V) ||
                (pattern == PAT_XH_H_F) || (pattern == PAT_XH_V_F);
    is_vert   = is_xhatch ? vertical_phase :
                ((pattern == PAT_VERT) || (pattern == PAT_VERT_F));
    active    = in_ch.sweep_end && (pattern != PAT_OFF) && (pattern <= PAT_XH_V_F);

    if (is_vert) begin
      tab_len = is_fine ? VTF_LEN : VT_LEN;
    end else begin
      tab_len = is_fine ? HZF_LEN : HZ_LEN;
    end

    // out-of-range step restarts the table
    step_cur = ({1'b0, step_index} >= tab_len) ? '0 : step_index;
    step_inc = {1'b0, step_cur} + 7'd1;
    wrap     = (step_inc >= tab_len);

    case ({is_vert, is_fine})
      2'b00:   level = TAB_H[step_cur[3:0]];
      2'b01:   level = TAB_HF[step_cur];
      2'b10:   level = TAB_V[step_cur[3:0]];
      2'b11:   level = TAB_VF[step_cur];
      default: level = '0;
    endcase

    // dots: step_index holds the remainder by 11, dot_quo the quotient
    dot_rem = ({1'b0, step_index} >= HZ_LEN) ? '0 : step_index[3:0];
    dot_row = ({3'b000, dot_quo} >= VT_LEN) ? '0 : dot_quo;

    y_load     = 1'b0;
    y_level    = '0;
    x_load     = 1'b0;
    x_level    = '0;
    mode_load  = 1'b0;
    mode_value = 1'b0;
    step_index_next     = step_index;
    dot_quo_next        = dot_quo;
    vertical_phase_next = vertical_phase;

    if (active) begin
      if (is_dots) begin
        y_load  = 1'b1;
        y_level = TAB_H[dot_rem];
        x_load  = 1'b1;
        x_level = TAB_V[dot_row];
        if ({3'b000, dot_rem} == HZ_LEN - 7'd1) begin
          step_index_next = '0;
          dot_quo_next    = ({3'b000, dot_row} == VT_LEN - 7'd1) ? '0 : dot_row + 4'd1;
        end else begin
          step_index_next = {2'b00, dot_rem + 4'd1};
          dot_quo_next    = dot_row;
        end
      end else begin
        if (is_vert) begin
          x_load  = 1'b1;
          x_level = level;
        end else begin
          y_load  = 1'b1;
          y_level = level;
        end
        step_index_next = wrap ? '0 : step_inc[5:0];
        if (wrap && is_xhatch) begin
          vertical_phase_next = !is_vert;
          mode_load           = 1'b1;
          mode_value          = !is_vert;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= PAT_RESET;
      step_index     <= '0;
      dot_quo        <= '0;
      vertical_phase <= 1'b0;
    end else if (cfg_we) begin
      pattern        <= cfg_data;
      step_index     <= '0;
      dot_quo        <= '0;
      vertical_phase <= (cfg_data == PAT_XH_V) || (cfg_data == PAT_XH_V_F);
    end else if (fire) begin
      step_index     <= step_index_next;
      dot_quo        <= dot_quo_next;
      vertical_phase <= vertical_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_y_load     <= y_load;
      r_y_level    <= y_level;
      r_x_load     <= x_load;
      r_x_level    <= x_level;
      r_mode_load  <= mode_load;
      r_mode_value <= mode_value;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.y_load     = r_y_load;
  assign out_ch.y_level    = r_y_level;
  assign out_ch.x_load     = r_x_load;
  assign out_ch.x_level    = r_x_level;
  assign out_ch.mode_load  = r_mode_load;
  assign out_ch.mode_value = r_mode_value;

  // a phase flip happens on a single-axis step and names the other axis
  a_mode_flip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && r_mode_load) |->
      ((r_x_load != r_y_load) && (r_mode_value == r_y_load)))
    else $error("mode load not tied to a single-axis wrap");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> ((step_index == '0) && (dot_quo == '0)))
    else $error("pattern write did not clear the step counters");

  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    ({3'b000, dot_quo} < VT_LEN))
    else $error("dots quotient out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(r_y_level) && $stable(r_x_level)))
    else $error("pending result changed while stalled");

endmodule

>>> tb/graticule_line_stepper_tb.sv
// testbench for the graticule line stepper: directed table, random pattern phases, then the unused codes
module graticule_line_stepper_tb
  import gls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   y_load;
    level_t y_level;
    logic   x_load;
    level_t x_level;
    logic   mode_load;
    logic   mode_value;
  } dac_loads_t;

  typedef struct packed {
    logic       do_cfg;
    pattern_t   pat;
    logic       sweep;
    logic [7:0] reps;
    logic       typed;
    dac_loads_t want;
  } plan_row_t;

  // codes past the last pattern behave like off
  localparam pattern_t PAT_UNUSED_LO = 4'd10;
  localparam pattern_t PAT_UNUSED_HI = 4'd15;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DOT_COUNT = HZ_LEN * VT_LEN;

  localparam dac_loads_t NO_LOADS = '0;

  localparam plan_row_t DIRECTED_PLAN [15] = '{
    '{1'b0, PAT_OFF,       1'b1, 8'd1,  1'b1, '{1'b1, 8'd68, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b0, PAT_OFF,       1'b0, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_OFF,       1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_HORIZ,     1'b1, 8'd1,  1'b1, '{1'b1, 8'd68, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_VERT,      1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b1, 8'd48, 1'b0, 1'b0}},
    '{1'b1, PAT_XH_H,      1'b1, 8'd1,  1'b1, '{1'b1, 8'd68, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_XH_V,      1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b1, 8'd48, 1'b0, 1'b0}},
    '{1'b1, PAT_DOTS,      1'b1, 8'd1,  1'b1, '{1'b1, 8'd68, 1'b1, 8'd48, 1'b0, 1'b0}},
    '{1'b1, PAT_HORIZ_F,   1'b1, 8'd1,  1'b1, '{1'b1, 8'd68, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_VERT_F,    1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b1, 8'd48, 1'b0, 1'b0}},
    '{1'b1, PAT_XH_V_F,    1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b1, 8'd48, 1'b0, 1'b0}},
    '{1'b1, PAT_UNUSED_HI, 1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b1, PAT_UNUSED_LO, 1'b1, 8'd1,  1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
    // walk a coarse crosshatch up to its last horizontal line, then the phase flip
    '{1'b1, PAT_XH_H,      1'b1, 8'd10, 1'b0, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
    '{1'b0, PAT_OFF,       1'b1, 8'd1,  1'b1, '{1'b1, 8'd228, 1'b0, 8'd0, 1'b1, 1'b1}}
  };

  localparam pattern_t RANDOM_PHASES [10] = '{
    PAT_HORIZ, PAT_VERT, PAT_XH_H, PAT_XH_V, PAT_DOTS,
    PAT_HORIZ_F, PAT_VERT_F, PAT_XH_H_F, PAT_XH_V_F, PAT_OFF
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_data;

  gls_in_if  in_ch ();
  gls_out_if out_ch ();

  graticule_line_stepper uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pattern_t   model_pattern;
  int         model_step;
  logic       model_vphase;
  dac_loads_t pending_loads [$];
  int         mismatches;
  int         cycles;
  bit         calm;
  logic       typed_pending;
  dac_loads_t typed_loads;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void load_pattern(input pattern_t p);
    model_pattern = p;
    model_step = 0;
    model_vphase = (p == PAT_XH_V || p == PAT_XH_V_F);
  endfunction

  // one sweep-end event: the levels it loads, and the counter and phase it leaves
  function automatic dac_loads_t advance_stepper(input logic sweep);
    dac_loads_t r;
    int s;
    int len;
    logic vert;
    logic fine;
    logic xhatch;
    r = '0;
    if (!sweep || model_pattern == PAT_OFF || model_pattern > PAT_XH_V_F) return r;
    s = model_step;
    if (model_pattern == PAT_DOTS) begin
      if (s >= DOT_COUNT) s = 0;
      r.y_load = 1'b1;
      r.y_level = TAB_H[s % HZ_LEN];
      r.x_load = 1'b1;
      r.x_level = TAB_V[s / HZ_LEN];
      s++;
      if (s >= DOT_COUNT) s = 0;
      model_step = s;
      return r;
    end
    fine = (model_pattern >= PAT_HORIZ_F);
    xhatch = 1'b0;
    case (model_pattern)
      PAT_HORIZ, PAT_HORIZ_F: vert = 1'b0;
      PAT_VERT, PAT_VERT_F: vert = 1'b1;
      default: begin
        xhatch = 1'b1;
        vert = model_vphase;
      end
    endcase
    if (vert) len = fine ? VTF_LEN : VT_LEN;
    else len = fine ? HZF_LEN : HZ_LEN;
    if (s >= len) s = 0;
    if (vert) begin
      r.x_load = 1'b1;
      r.x_level = fine ? TAB_VF[s] : TAB_V[s];
    end else begin
      r.y_load = 1'b1;
      r.y_level = fine ? TAB_HF[s] : TAB_H[s];
    end
    s++;
    if (s >= len) begin
      s = 0;
      if (xhatch) begin
        model_vphase = !vert;
        r.mode_load = 1'b1;
        r.mode_value = model_vphase;
      end
    end
    model_step = s;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic send_request(input logic sweep, input logic typed, input dac_loads_t want);
    while (!calm && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sweep_end <= sweep;
    typed_pending = typed;
    typed_loads = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_pattern(input pattern_t p);
    in_ch.valid <= 1'b0;
    while (pending_loads.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !rst && (calm || $urandom_range(99) >= 37);
  end

  always @(posedge clk) begin : scoreboard
    dac_loads_t want;
    dac_loads_t got;
    if (rst) begin
      load_pattern(PAT_RESET);
      pending_loads.delete();
    end else begin
      if (cfg_we) load_pattern(cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        want = advance_stepper(in_ch.sweep_end);
        pending_loads.push_back(typed_pending ? typed_loads : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.y_load, out_ch.y_level, out_ch.x_load, out_ch.x_level,
                out_ch.mode_load, out_ch.mode_value};
        if (pending_loads.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_loads.pop_front();
          check_field("y_load", got.y_load, want.y_load);
          check_field("y_level", got.y_level, want.y_level);
          check_field("x_load", got.x_load, want.x_load);
          check_field("x_level", got.x_level, want.x_level);
          check_field("mode_load", got.mode_load, want.mode_load);
          check_field("mode_value", got.mode_value, want.mode_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("graticule_line_stepper_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int n;
    int fired;
    logic sweep;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sweep_end = 1'b0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    typed_pending = 1'b0;
    typed_loads = NO_LOADS;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].do_cfg) write_pattern(DIRECTED_PLAN[i].pat);
      repeat (DIRECTED_PLAN[i].reps)
        send_request(DIRECTED_PLAN[i].sweep, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // phase lengths cover at least one full table, two phase flips for crosshatch
    foreach (RANDOM_PHASES[i]) begin
      write_pattern(RANDOM_PHASES[i]);
      case (RANDOM_PHASES[i])
        PAT_HORIZ, PAT_VERT: n = 25;
        PAT_XH_H, PAT_XH_V: n = 40;
        PAT_DOTS: n = 150;
        PAT_HORIZ_F: n = 55;
        PAT_VERT_F: n = 66;
        PAT_XH_H_F, PAT_XH_V_F: n = 120;
        default: n = 4;
      endcase
      // no idling on either side through the dots phase
      calm = (RANDOM_PHASES[i] == PAT_DOTS);
      fired = 0;
      while (fired < n) begin
        sweep = ($urandom_range(9) != 0);
        send_request(sweep, 1'b0, NO_LOADS);
        if (sweep) fired++;
      end
      calm = 1'b0;
    end
    for (int p = PAT_UNUSED_LO; p <= PAT_UNUSED_HI; p++) begin
      write_pattern(pattern_t'(p));
      repeat (4) send_request(1'($urandom_range(1)), 1'b0, NO_LOADS);
    end

    in_ch.valid <= 1'b0;
    while (pending_loads.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("graticule_line_stepper_tb OK");
    end else begin
      $display("graticule_line_stepper_tb NOT OK");
    end
    $finish;
  end

endmodule
